>>> rtl/hpt_pkg.sv
// Shared constants, types and register codes of the heading PID turn controller.
`default_nettype none

package hpt_pkg;

    localparam int SUM_WIDTH      = 48;
    localparam int GAIN_FRAC_BITS = 32;
    localparam int GAIN_INT_BITS  = 8;
    localparam int GAIN_W         = GAIN_INT_BITS + GAIN_FRAC_BITS;

    localparam int HEAD_W  = 16;
    localparam int ERR_W   = HEAD_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int BAND_W  = 8;
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;

    localparam int CFG_W      = GAIN_W;
    localparam int CFG_ADDR_W = 3;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Integral product is built from 24-bit slices of the error sum, high slice first
    localparam int CHUNK_W    = 24;
    localparam int SUM_CHUNKS = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int SUM_EXT_W  = SUM_CHUNKS * CHUNK_W;
    localparam int NSTEPS     = SUM_CHUNKS + 2;
    localparam int STEP_W     = $clog2(NSTEPS);

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = CHUNK_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = SUM_WIDTH + GAIN_W + 2;
    localparam int IP_W    = ACC_W - GAIN_FRAC_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic signed [HEAD_W-1:0] TARGET_RST = '0;
    localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = GAIN_W'(64'd1288490189);
    localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = GAIN_W'(64'd129);
    localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = GAIN_W'(64'd85899345920);
    localparam logic [BAND_W-1:0]  BAND_RST       = BAND_W'(1);
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = LIMIT_W'(200);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_KD     = 3'd3,
        REG_BAND   = 3'd4,
        REG_LIMIT  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] target;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
        logic [BAND_W-1:0]        band;
        logic [LIMIT_W-1:0]       limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [DIFF_W-1:0]    diff;
        logic signed [SUM_WIDTH-1:0] sum;
        logic                        settled;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/hpt_cfg.sv
// Configuration register file: target, gains, settle band and drive limit.
`default_nettype none

module hpt_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [hpt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [hpt_pkg::CFG_W-1:0]        cfg_wdata,
    output hpt_pkg::cfg_t                         cfg
);

    hpt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= hpt_pkg::TARGET_RST;
            cfg_reg.kp     <= hpt_pkg::GAIN_PROP_RST;
            cfg_reg.ki     <= hpt_pkg::GAIN_INTEG_RST;
            cfg_reg.kd     <= hpt_pkg::GAIN_DERIV_RST;
            cfg_reg.band   <= hpt_pkg::BAND_RST;
            cfg_reg.limit  <= hpt_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hpt_pkg::REG_TARGET: cfg_reg.target <= cfg_wdata[hpt_pkg::HEAD_W-1:0];
                hpt_pkg::REG_KP:     cfg_reg.kp     <= cfg_wdata[hpt_pkg::GAIN_W-1:0];
                hpt_pkg::REG_KI:     cfg_reg.ki     <= cfg_wdata[hpt_pkg::GAIN_W-1:0];
                hpt_pkg::REG_KD:     cfg_reg.kd     <= cfg_wdata[hpt_pkg::GAIN_W-1:0];
                hpt_pkg::REG_BAND:   cfg_reg.band   <= cfg_wdata[hpt_pkg::BAND_W-1:0];
                hpt_pkg::REG_LIMIT:  cfg_reg.limit  <= cfg_wdata[hpt_pkg::LIMIT_W-1:0];
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/hpt_front.sv
// Front end: takes samples, forms error, saturating sum and difference, flags settle.
`default_nettype none

module hpt_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [hpt_pkg::S_DATA_W-1:0]         s_tdata,
    input  wire logic signed [hpt_pkg::HEAD_W-1:0]    target,
    input  wire logic [hpt_pkg::BAND_W-1:0]           band,
    input  wire logic                                 q_full,
    output logic                                      push,
    output hpt_pkg::item_t                            push_item
);

    localparam int SW = hpt_pkg::SUM_WIDTH;

    logic signed [SW-1:0]                  sum_reg, sum_next;
    logic signed [hpt_pkg::ERR_W-1:0]      prev_reg;
    logic signed [hpt_pkg::HEAD_W-1:0]     sample;
    logic                                  restart;
    logic signed [hpt_pkg::ERR_W-1:0]      err, prev_base;
    logic [hpt_pkg::ERR_W-1:0]             err_mag;
    logic signed [SW-1:0]                  sum_base;
    logic signed [SW:0]                    sum_wide;
    logic signed [hpt_pkg::DIFF_W-1:0]     diff;

    assign sample   = s_tdata[hpt_pkg::HEAD_W-1:0];
    assign restart  = s_tdata[hpt_pkg::HEAD_W];
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        sum_base  = restart ? '0 : sum_reg;
        prev_base = restart ? '0 : prev_reg;
        err       = hpt_pkg::ERR_W'(target) - hpt_pkg::ERR_W'(sample);
        err_mag   = err[hpt_pkg::ERR_W-1] ? hpt_pkg::ERR_W'(-err) : err;
        sum_wide  = (SW+1)'(sum_base) + (SW+1)'(err);
        // clamp on signed overflow of the accumulated error
        if (sum_wide[SW] != sum_wide[SW-1])
            sum_next = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            sum_next = sum_wide[SW-1:0];
        diff = hpt_pkg::DIFF_W'(err) - hpt_pkg::DIFF_W'(prev_base);

        push_item.err     = err;
        push_item.diff    = diff;
        push_item.sum     = sum_next;
        push_item.settled = err_mag <= hpt_pkg::ERR_W'(band);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (push)
        begin
            sum_reg  <= sum_next;
            prev_reg <= err;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hpt_queue.sv
// Short FIFO between the front end and the multiply back end.
`default_nettype none

module hpt_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire hpt_pkg::item_t push_item,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output hpt_pkg::item_t head_item
);

    hpt_pkg::item_t                  entry_reg [hpt_pkg::QUEUE_DEPTH];
    logic [hpt_pkg::QPTR_W-1:0]      wr_reg, rd_reg;
    logic [hpt_pkg::QCNT_W-1:0]      cnt_reg;
    logic                            do_pop;

    assign full       = cnt_reg == hpt_pkg::QCNT_W'(hpt_pkg::QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = entry_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hpt_back.sv
// Back end: shared multiplier sequence for I, P, D terms, accumulate, truncate, saturate.
`default_nettype none

module hpt_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire hpt_pkg::item_t                q_item,
    output logic                               q_pop,
    input  wire hpt_pkg::cfg_t                 cfg,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hpt_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int SC = hpt_pkg::SUM_CHUNKS;
    localparam int CW = hpt_pkg::CHUNK_W;
    localparam int FB = hpt_pkg::GAIN_FRAC_BITS;

    // sequencer
    logic                          busy_reg;
    logic [hpt_pkg::STEP_W-1:0]    step_reg;
    hpt_pkg::item_t                cur_reg;
    logic                          last_step, stall, issue;

    // multiplier operands and product stage
    logic signed [hpt_pkg::SUM_WIDTH-1:0]  cur_sum;
    logic signed [hpt_pkg::SUM_EXT_W-1:0]  sum_ext;
    logic [hpt_pkg::GAIN_W-1:0]            gain;
    logic signed [hpt_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [hpt_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [hpt_pkg::PROD_W-1:0]     prod_reg;
    logic                                  pv_reg, p_first_reg, p_shift_reg, p_last_reg;
    logic                                  p_settled_reg;

    // accumulator and finish
    logic signed [hpt_pkg::ACC_W-1:0]      acc_reg, acc_next, prod_ext, biased;
    logic                                  done_reg, done_settled_reg;
    logic signed [hpt_pkg::IP_W-1:0]       ipart, lim_s;
    logic signed [hpt_pkg::DRIVE_W-1:0]    drive;
    logic                                  clipped, out_free;

    logic                                  m_tvalid_reg;
    logic [hpt_pkg::M_DATA_W-1:0]          m_tdata_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign stall     = done_reg && !out_free;
    assign last_step = busy_reg && (step_reg == hpt_pkg::STEP_W'(hpt_pkg::NSTEPS - 1));
    assign issue     = busy_reg && !stall;
    assign q_pop     = q_valid && !stall && (!busy_reg || last_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (!stall)
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (last_step)
                busy_reg <= 1'b0;
            else if (busy_reg)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
    end

    // Steps: integral slices high to low, then proportional, then derivative
    always_comb
    begin
        cur_sum = cur_reg.sum;
        sum_ext = hpt_pkg::SUM_EXT_W'(cur_sum);
        gain    = cfg.ki;
        mul_b   = '0;
        for (int k = 0; k < SC; k++)
        begin
            if (step_reg == hpt_pkg::STEP_W'(SC - 1 - k))
            begin
                if (k == SC - 1)
                    mul_b = hpt_pkg::MUL_B_W'($signed(sum_ext[k*CW +: CW]));
                else
                    mul_b = $signed({1'b0, sum_ext[k*CW +: CW]});
            end
        end
        if (step_reg == hpt_pkg::STEP_W'(SC))
        begin
            gain  = cfg.kp;
            mul_b = hpt_pkg::MUL_B_W'(cur_reg.err);
        end
        else if (step_reg == hpt_pkg::STEP_W'(SC + 1))
        begin
            gain  = cfg.kd;
            mul_b = hpt_pkg::MUL_B_W'(cur_reg.diff);
        end
        mul_a = $signed({1'b0, gain});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (!stall)
            pv_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg      <= mul_a * mul_b;
            p_first_reg   <= step_reg == '0;
            p_shift_reg   <= (step_reg != '0) && (step_reg < hpt_pkg::STEP_W'(SC));
            p_last_reg    <= last_step;
            p_settled_reg <= cur_reg.settled;
        end
    end

    always_comb
    begin
        prod_ext = hpt_pkg::ACC_W'(prod_reg);
        if (p_first_reg)
            acc_next = prod_ext;
        else if (p_shift_reg)
            acc_next = (acc_reg <<< CW) + prod_ext;
        else
            acc_next = acc_reg + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        if (pv_reg && !stall)
            acc_reg <= acc_next;
        if (pv_reg && p_last_reg && !stall)
            done_settled_reg <= p_settled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (!stall)
            done_reg <= pv_reg && p_last_reg;
    end

    // truncate toward zero: bias negative totals by one below the integer step
    always_comb
    begin
        biased  = acc_reg + (acc_reg[hpt_pkg::ACC_W-1]
                  ? $signed({{(hpt_pkg::ACC_W-FB){1'b0}}, {FB{1'b1}}})
                  : $signed({hpt_pkg::ACC_W{1'b0}}));
        ipart   = biased[hpt_pkg::ACC_W-1:FB];
        lim_s   = $signed({{(hpt_pkg::IP_W-hpt_pkg::LIMIT_W){1'b0}}, cfg.limit});
        clipped = 1'b0;
        if (ipart > lim_s)
        begin
            drive   = hpt_pkg::DRIVE_W'(lim_s);
            clipped = 1'b1;
        end
        else if (ipart < -lim_s)
        begin
            drive   = hpt_pkg::DRIVE_W'(-lim_s);
            clipped = 1'b1;
        end
        else
            drive = ipart[hpt_pkg::DRIVE_W-1:0];
        if (done_settled_reg)
        begin
            drive   = '0;
            clipped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (done_reg && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_reg && out_free)
            m_tdata_reg <= {{(hpt_pkg::M_DATA_W - 2*hpt_pkg::DRIVE_W - 2){1'b0}},
                            clipped, done_settled_reg,
                            hpt_pkg::DRIVE_W'(-drive), drive};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/heading_pid_turn.sv
// Heading PID turn controller: top level.
//
// Slave stream s_*: one transfer per control tick carrying a gyro heading sample
// and a restart flag. Master stream m_*: one transfer per input with left/right
// drive commands, a settled flag and a clipped flag.
// Config port cfg_*: one register written per cycle with cfg_we high; write only
// while no sample is in flight.
// Each sample passes the queue, the product register, the accumulator and the
// output register. The single shared 41x25 multiplier handles two integral
// slices, then P, then D, and takes the next sample while the last accumulates.
// The front end updates error sum and previous error at the input transfer and
// queues up to 4 samples, so short bursts are absorbed at one per cycle until full.
// Reset clears the error sum, the previous error, the queue and the pipeline,
// and loads the registers with their default gains, band and limit.
// When the receiver stalls, the result holds on m_*; the back end stops with one
// finished result pending, then the queue fills and s_tready drops.
`default_nettype none

module heading_pid_turn (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hpt_pkg::S_DATA_W-1:0]      s_tdata,   // heading_sample[15:0], restart[16]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hpt_pkg::M_DATA_W-1:0]           m_tdata,   // left_drive[15:0], right_drive[31:16],
                                                              // settled[32], clipped[33]
    input  wire logic                              cfg_we,
    input  wire logic [hpt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [hpt_pkg::CFG_W-1:0]         cfg_wdata
);

    hpt_pkg::cfg_t  cfg;
    hpt_pkg::item_t push_item, head_item;
    logic           push, q_full, q_pop, head_valid;

    hpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .target    (cfg.target),
        .band      (cfg.band),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    hpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    hpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/hpt_checker.sv
// Port-level checks on the result stream, bound to the top level.
`default_nettype none

module hpt_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [hpt_pkg::M_DATA_W-1:0]      m_tdata
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:16] == 16'(~m_tdata[15:0] + 16'd1))
        else $error("right drive is not the negated left drive");

    a_settled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[15:0] == 16'd0 && !m_tdata[33])
        else $error("settled result with nonzero drive or clip");

endmodule

bind heading_pid_turn hpt_checker u_hpt_checker (.*);

`default_nettype wire
